FILE: hw/rtl/m3inv_pkg.sv
// Package for the 3x3 matrix inverse block.
// Shared widths, cofactor operand tables, status codes and lane types.
// No dependencies.
`default_nettype none

package m3inv_pkg;

   localparam int unsigned ELEM_W  = 32;   // Q16.16 element
   localparam int unsigned NELEM   = 9;
   localparam int unsigned COF_W   = 64;   // exact cofactor, Q32.32
   localparam int unsigned DET_W   = 97;   // exact determinant, Q48.48
   localparam int unsigned QUO_W   = 32;   // quotient bits produced per lane
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned REQ_W   = ELEM_W * NELEM;
   localparam int unsigned RES_W   = ELEM_W * NELEM + STAT_W;
   localparam int unsigned RSP_W   = ((RES_W + 7) / 8) * 8;

   typedef logic [3:0] idx_type;

   // cofactor k = a[CF_X]*a[CF_Y] - a[CF_U]*a[CF_V]
   localparam idx_type CF_X [NELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam idx_type CF_Y [NELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam idx_type CF_U [NELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam idx_type CF_V [NELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   // side information that travels with each lane's quotient
   typedef struct packed {
      logic neg;    // result sign
      logic ovf;    // quotient at least 2^32
      logic sing;   // determinant zero
   } lane_meta_type;

endpackage

`default_nettype wire

FILE: hw/rtl/m3inv_cof.sv
// Cofactor unit: eighteen paired products, then the nine adjugate cofactors.
// Depends on m3inv_pkg.
`default_nettype none

module m3inv_cof
   import m3inv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [ELEM_W-1:0] a_in [NELEM],
   output logic                          out_valid,
   output logic signed [COF_W-1:0]       cof [NELEM],
   output logic signed [ELEM_W-1:0]      row0 [3]
);

   logic                      v1_ff, v2_ff;
   logic signed [COF_W-1:0]   pl_ff [NELEM];
   logic signed [COF_W-1:0]   pr_ff [NELEM];
   logic signed [ELEM_W-1:0]  r1_ff [3];
   logic signed [ELEM_W-1:0]  r2_ff [3];
   logic signed [COF_W-1:0]   cof_ff [NELEM];

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // products, then differences
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NELEM; k++) begin
            pl_ff[k]  <= a_in[CF_X[k]] * a_in[CF_Y[k]];
            pr_ff[k]  <= a_in[CF_U[k]] * a_in[CF_V[k]];
            cof_ff[k] <= pl_ff[k] - pr_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            r1_ff[j] <= a_in[j];
            r2_ff[j] <= r1_ff[j];
         end
      end
   end

   assign out_valid = v2_ff;
   assign cof       = cof_ff;
   assign row0      = r2_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/m3inv_det.sv
// Determinant unit: first-row expansion in 32x32 partial products, then
// sign and magnitude of the determinant and of each cofactor for the lanes.
// Depends on m3inv_pkg.
`default_nettype none

module m3inv_det
   import m3inv_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [COF_W-1:0]  cof [NELEM],
   input  wire logic signed [ELEM_W-1:0] row0 [3],
   output logic                          out_valid,
   output logic [COF_W-1:0]              cmag [NELEM],
   output logic                          rneg [NELEM],
   output logic [DET_W-1:0]              dmag,
   output logic                          sing
);

   logic                      v_ff [4];
   logic signed [COF_W-1:0]   c_ff [3][NELEM];
   logic signed [COF_W-1:0]   hi_ff [3];
   logic signed [COF_W:0]     lo_ff [3];
   logic signed [DET_W-1:0]   t_ff [3];
   logic signed [DET_W-1:0]   det_ff;
   logic [COF_W-1:0]          cmag_ff [NELEM];
   logic                      rneg_ff [NELEM];
   logic [DET_W-1:0]          dmag_ff;
   logic                      sing_ff;
   logic                      dneg;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < 4; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   assign dneg = det_ff[DET_W-1];

   // partial products, terms, sum, sign split
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            hi_ff[j] <= row0[j] * $signed(cof[3*j][COF_W-1:ELEM_W]);
            lo_ff[j] <= row0[j] * $signed({1'b0, cof[3*j][ELEM_W-1:0]});
            t_ff[j]  <= $signed({hi_ff[j][COF_W-1], hi_ff[j], {ELEM_W{1'b0}}})
                      + $signed({{ELEM_W{lo_ff[j][COF_W]}}, lo_ff[j]});
         end
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
         c_ff[0] <= cof;
         c_ff[1] <= c_ff[0];
         c_ff[2] <= c_ff[1];
         for (int k = 0; k < NELEM; k++) begin
            cmag_ff[k] <= c_ff[2][k][COF_W-1] ? COF_W'(-c_ff[2][k]) : COF_W'(c_ff[2][k]);
            rneg_ff[k] <= c_ff[2][k][COF_W-1] ^ dneg;
         end
         dmag_ff <= dneg ? DET_W'(-det_ff) : DET_W'(det_ff);
         sing_ff <= (det_ff == '0);
      end
   end

   assign out_valid = v_ff[3];
   assign cmag      = cmag_ff;
   assign rneg      = rneg_ff;
   assign dmag      = dmag_ff;
   assign sing      = sing_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/m3inv_lane.sv
// Division lane: pipelined restoring divider, one quotient bit per stage,
// giving floor(cmag * 2^32 / dmag) and an overflow flag.
// Depends on m3inv_pkg.
`default_nettype none

module m3inv_lane
   import m3inv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic [COF_W-1:0]   cmag,
   input  wire logic [DET_W-1:0]   dmag,
   input  wire logic               neg,
   input  wire logic               sing,
   output logic                    out_valid,
   output logic [QUO_W-1:0]        quo,
   output lane_meta_type           meta
);

   logic                 v_ff [QUO_W+1];
   logic [DET_W-1:0]     r_ff [QUO_W+1];
   logic [DET_W-1:0]     d_ff [QUO_W+1];
   logic [QUO_W-1:0]     q_ff [QUO_W+1];
   lane_meta_type        m_ff [QUO_W+1];

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= QUO_W; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   // load: the remainder starts as the cofactor magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]      <= DET_W'(cmag);
         d_ff[0]      <= dmag;
         q_ff[0]      <= '0;
         m_ff[0].neg  <= neg;
         m_ff[0].ovf  <= ({{(DET_W-COF_W){1'b0}}, cmag} >= dmag);
         m_ff[0].sing <= sing;
      end
   end

   // one shift-compare-subtract per stage
   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      logic [DET_W:0] t;
      logic           ge;
      assign t  = {r_ff[s-1], 1'b0};
      assign ge = (t >= {1'b0, d_ff[s-1]});
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s] <= ge ? DET_W'(t - {1'b0, d_ff[s-1]}) : DET_W'(t);
            d_ff[s] <= d_ff[s-1];
            q_ff[s] <= {q_ff[s-1][QUO_W-2:0], ge};
            m_ff[s] <= m_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign quo       = q_ff[QUO_W];
   assign meta      = m_ff[QUO_W];

endmodule

`default_nettype wire

FILE: hw/rtl/m3inv_merge.sv
// Merge stage: signs and saturates the nine lane quotients, forms status,
// and holds results in a two-entry output queue.
// Depends on m3inv_pkg.
`default_nettype none

module m3inv_merge
   import m3inv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [QUO_W-1:0]   quo [NELEM],
   input  wire lane_meta_type      meta [NELEM],
   output logic                    en,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [RES_W-1:0]        out_data
);

   logic [RES_W-1:0]   mem_ff [2];
   logic               wp_ff, rp_ff;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push, pop;
   logic [RES_W-1:0]   res;
   logic [NELEM-1:0]   sat;
   status_type         st;

   // sign and saturate each element
   always_comb begin
      logic [QUO_W-1:0] v;
      logic [QUO_W-1:0] lim;
      logic             ovr;
      res = '0;
      for (int k = 0; k < NELEM; k++) begin
         lim = meta[k].neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
         ovr = meta[k].ovf || (quo[k] > lim);
         sat[k] = ovr;
         v = ovr ? lim : quo[k];
         if (!meta[0].sing)
            res[k*ELEM_W +: ELEM_W] = meta[k].neg ? ELEM_W'(-v) : v;
      end
      if (meta[0].sing)   st = STATUS_SINGULAR;
      else if (|sat)      st = STATUS_SATURATED;
      else                st = STATUS_OK;
      res[RES_W-1 -: STAT_W] = st;
   end

   assign en        = (cnt_ff != 2'd2);
   assign push      = in_valid && en;
   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   // queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= res;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("output queue count out of range");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("output queue count missed a push");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (push && meta[0].sing) |-> (res[NELEM*ELEM_W-1:0] == '0))
      else $error("singular item with nonzero elements");

endmodule

`default_nettype wire

FILE: hw/rtl/matrix3x3_inverse.sv
// 3x3 matrix inverse by adjugate and determinant, Q16.16 in and out.
// Register stages from input to result: 1 input register, 2 cofactor, 4 determinant,
// 33 division, 1 queue; the whole pipeline holds while the output queue is full.
// Throughput: one item per cycle while the output queue is not full;
// nine division lanes run side by side.
// Reset: synchronous, active high; clears valid bits and the output queue.
`default_nettype none

module matrix3x3_inverse
   import m3inv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata    // q00..q22, status[1:0], zero fill
);

   logic                      en;
   logic                      v_in_ff;
   logic signed [ELEM_W-1:0]  a_ff [NELEM];
   logic                      cof_valid, det_valid;
   logic signed [COF_W-1:0]   cof [NELEM];
   logic signed [ELEM_W-1:0]  row0 [3];
   logic [COF_W-1:0]          cmag [NELEM];
   logic                      rneg [NELEM];
   logic [DET_W-1:0]          dmag;
   logic                      sing;
   logic [NELEM-1:0]          lane_valid;
   logic [QUO_W-1:0]          quo [NELEM];
   lane_meta_type             meta [NELEM];
   logic [RES_W-1:0]          res;

   assign req_tready = en;

   // input register
   always_ff @(posedge clock) begin
      if (reset)   v_in_ff <= 1'b0;
      else if (en) v_in_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NELEM; k++)
            a_ff[k] <= $signed(req_tdata[k*ELEM_W +: ELEM_W]);
      end
   end

   m3inv_cof u_cof (
      .clock, .reset, .en,
      .in_valid (v_in_ff),
      .a_in     (a_ff),
      .out_valid(cof_valid),
      .cof, .row0
   );

   m3inv_det u_det (
      .clock, .reset, .en,
      .in_valid (cof_valid),
      .cof, .row0,
      .out_valid(det_valid),
      .cmag, .rneg, .dmag, .sing
   );

   for (genvar k = 0; k < NELEM; k++) begin : g_lane
      m3inv_lane u_lane (
         .clock, .reset, .en,
         .in_valid (det_valid),
         .cmag     (cmag[k]),
         .dmag,
         .neg      (rneg[k]),
         .sing,
         .out_valid(lane_valid[k]),
         .quo      (quo[k]),
         .meta     (meta[k])
      );
   end

   m3inv_merge u_merge (
      .clock, .reset,
      .in_valid (&lane_valid),
      .quo, .meta, .en,
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (res)
   );

   assign rsp_tdata = {{(RSP_W-RES_W){1'b0}}, res};

endmodule

`default_nettype wire

FILE: test/tb.sv
// Testbench for matrix3x3_inverse: random and directed 3x3 Q16.16 matrices,
// with an exact inverse computed on the side and checked per result item.
// Depends on m3inv_pkg and the matrix3x3_inverse RTL.
`timescale 1ns / 100ps

module tb
   import m3inv_pkg::*;
();

   localparam int NUM_RANDOM   = 1830;
   localparam int LATENCY      = 41;
   localparam int WATCHDOG_MAX = 20000;

   typedef logic signed [31:0] elem_type;
   typedef struct {
      elem_type  q[9];
      logic [1:0] status;
   } inverse_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   logic [REQ_W-1:0] pending_matrices[$];
   inverse_type expected_inverses[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit stimulus_done = 0;
   bit quiet_phase = 0;
   bit drain_hold = 0;       // sender holds until all results are back
   int hold_rsp = 0;         // long receiver hold-off, in cycles
   int send_gap = 0;
   int recv_gap = 0;

   matrix3x3_inverse DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // exact inverse: cofactors in 64 bits, determinant in 128, quotient truncated
   function automatic inverse_type invert_matrix(input logic [REQ_W-1:0] m);
      logic signed [63:0] a[9];
      logic signed [63:0] cof[9];
      logic signed [127:0] det;
      logic [127:0] det_mag, num, quo;
      logic neg;
      bit sat;
      inverse_type r;
      sat = 0;
      for (int k = 0; k < 9; k++) a[k] = $signed(m[32*k +: 32]);
      cof[0] = a[4]*a[8] - a[5]*a[7];
      cof[1] = a[2]*a[7] - a[1]*a[8];
      cof[2] = a[1]*a[5] - a[2]*a[4];
      cof[3] = a[5]*a[6] - a[3]*a[8];
      cof[4] = a[0]*a[8] - a[2]*a[6];
      cof[5] = a[2]*a[3] - a[0]*a[5];
      cof[6] = a[3]*a[7] - a[4]*a[6];
      cof[7] = a[1]*a[6] - a[0]*a[7];
      cof[8] = a[0]*a[4] - a[1]*a[3];
      det = 128'(a[0])*128'(cof[0]) + 128'(a[1])*128'(cof[3]) + 128'(a[2])*128'(cof[6]);
      if (det == 0) begin
         for (int k = 0; k < 9; k++) r.q[k] = '0;
         r.status = STATUS_SINGULAR;
         return r;
      end
      det_mag = det < 0 ? -det : det;
      for (int k = 0; k < 9; k++) begin
         num = cof[k] < 0 ? 128'(-128'(cof[k])) : 128'(cof[k]);
         num = num << 32;
         quo = num / det_mag;
         neg = (cof[k] < 0) != (det < 0);
         if (quo > (neg ? 128'h8000_0000 : 128'h7fff_ffff)) begin
            sat = 1;
            quo = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         end
         r.q[k] = neg ? -quo[31:0] : quo[31:0];
      end
      r.status = sat ? STATUS_SATURATED : STATUS_OK;
      return r;
   endfunction

   function automatic logic [REQ_W-1:0] pack_matrix(input elem_type e[9]);
      logic [REQ_W-1:0] m;
      for (int k = 0; k < 9; k++) m[32*k +: 32] = e[k];
      return m;
   endfunction

   function automatic elem_type random_element(input int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         2: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
         default: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
      endcase
   endfunction

   // build the stimulus list: directed matrices first, then random ones
   initial begin
      elem_type e[9];
      int mode;
      // identity and a diagonal matrix
      e = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
      pending_matrices.push_back(pack_matrix(e));
      e = '{32'sh20000, 0, 0, 0, -32'sh8000, 0, 0, 0, 32'sh40000};
      pending_matrices.push_back(pack_matrix(e));
      // singular: all zero, repeated rows
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      pending_matrices.push_back(pack_matrix(e));
      e = '{1, 2, 3, 1, 2, 3, 7, 8, 9};
      pending_matrices.push_back(pack_matrix(e));
      // saturation: tiny determinant
      e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      pending_matrices.push_back(pack_matrix(e));
      e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
      pending_matrices.push_back(pack_matrix(e));
      // extreme values
      for (int k = 0; k < 9; k++) e[k] = 32'sh7fffffff;
      pending_matrices.push_back(pack_matrix(e));
      for (int k = 0; k < 9; k++) e[k] = 32'sh80000000;
      pending_matrices.push_back(pack_matrix(e));
      e = '{32'sh80000000, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, -1};
      pending_matrices.push_back(pack_matrix(e));
      e = '{32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh80000000,
            32'sh80000000, 0, 32'sh7fffffff};
      pending_matrices.push_back(pack_matrix(e));
      // zero cofactors with nonzero determinant
      e = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000};
      pending_matrices.push_back(pack_matrix(e));
      for (int n = 0; n < NUM_RANDOM; n++) begin
         mode = $urandom_range(0, 3);
         for (int k = 0; k < 9; k++)
            e[k] = random_element($urandom_range(0, 7) == 0 ? 3 : mode);
         // occasionally force a singular matrix by copying a row
         if ($urandom_range(0, 15) == 0) begin
            e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
         end
         pending_matrices.push_back(pack_matrix(e));
      end
   end

   // reset, then mid-run pressure points
   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (pending_matrices.size() < 1300);
      @(posedge clock);
      hold_rsp <= 200;
      wait (pending_matrices.size() < 900);
      @(posedge clock);
      drain_hold <= 1;
      wait (expected_inverses.size() == 0);
      @(posedge clock);
      drain_hold <= 0;
      wait (pending_matrices.size() < 200);
      @(posedge clock);
      quiet_phase <= 1;
   end

   // driver: offer matrices, with random gaps
   always @(posedge clock) begin
      logic fire;
      logic next_valid;
      fire = req_tvalid && req_tready;
      if (fire) expected_inverses.push_back(invert_matrix(req_tdata));
      next_valid = req_tvalid && !fire;
      if (!reset && !next_valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (!drain_hold && pending_matrices.size() > 0) begin
            next_valid = 1;
            req_tdata <= pending_matrices.pop_front();
            if (!quiet_phase && $urandom_range(0, 9) == 0)
               send_gap <= $urandom_range(1, 16);
         end
      end
      req_tvalid <= next_valid;
      if (!reset && pending_matrices.size() == 0 && !next_valid) stimulus_done <= 1;
   end

   // monitor: accept results with random back-pressure and compare
   always @(posedge clock) begin
      inverse_type want;
      logic [31:0] got;
      bit bad;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            want = expected_inverses.pop_front();
            bad = 0;
            for (int k = 0; k < 9; k++) begin
               got = rsp_tdata[32*k +: 32];
               if (got !== want.q[k]) bad = 1;
            end
            if (rsp_tdata[288 +: 2] !== want.status) bad = 1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected status %0d q %h %h %h %h %h %h %h %h %h",
                     want.status, want.q[0], want.q[1], want.q[2], want.q[3], want.q[4],
                     want.q[5], want.q[6], want.q[7], want.q[8]);
                  $display("          actual %h", rsp_tdata);
               end
            end
         end
      end
      // receiver stalls
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
         rsp_tready <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         if (!quiet_phase && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 16);
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stimulus_done);
      wait (expected_inverses.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_inverses.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
